// File: hdl/cpr_pkg.sv
// ----------------------------------------------------------------------------
// Clock page replacement package
// Shared widths, controller states and the command/status bundles that join
// the controller and the datapath.
// ----------------------------------------------------------------------------
package cpr_pkg;

   localparam int ADDR_W      = 32;
   localparam int PAGE_SHIFT  = 12;
   localparam int PAGE_W      = ADDR_W - PAGE_SHIFT;
   localparam int FRAME_OUT_W = 2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MATCH,
      ST_SWEEP,
      ST_REPLY
   } ctrl_state_type;

   typedef struct packed {
      logic capture;
      logic hit_update;
      logic fill_empty;
      logic clear_step;
      logic replace;
   } cmd_type;

   typedef struct packed {
      logic hit;
      logic has_empty;
      logic use_at_hand;
   } status_type;

endpackage

// File: hdl/cpr_datapath.sv
// ----------------------------------------------------------------------------
// Clock page replacement datapath
// Frame table, use bits, clock hand and result registers, driven by commands
// from the controller.
// ----------------------------------------------------------------------------
module cpr_datapath
   import cpr_pkg::*;
#(
   parameter int FRAME_COUNT = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  cmd_type                cmd,
   output status_type             status,
   input  logic [ADDR_W-1:0]      req_access_address,
   output logic                   rsp_hit,
   output logic [FRAME_OUT_W-1:0] rsp_frame_index,
   output logic [PAGE_W-1:0]      rsp_page_number,
   output logic                   rsp_evicted_valid,
   output logic [PAGE_W-1:0]      rsp_evicted_page
);

   localparam int HW = $clog2(FRAME_COUNT);

   logic [PAGE_W-1:0]      page_ff     [FRAME_COUNT];
   logic [PAGE_W-1:0]      page_in     [FRAME_COUNT];
   logic [FRAME_COUNT-1:0] valid_ff, valid_in;
   logic [FRAME_COUNT-1:0] use_ff, use_in;
   logic [HW-1:0]          hand_ff, hand_in;
   logic [PAGE_W-1:0]      req_page_ff, req_page_in;
   logic                   hit_ff, hit_in;
   logic [HW-1:0]          frame_ff, frame_in;
   logic                   ev_valid_ff, ev_valid_in;
   logic [PAGE_W-1:0]      ev_page_ff, ev_page_in;

   logic                   any_hit;
   logic [HW-1:0]          hit_idx;
   logic                   any_empty;
   logic [HW-1:0]          empty_idx;
   logic [HW-1:0]          next_hand;

   always_comb begin
      any_hit   = 1'b0;
      hit_idx   = '0;
      any_empty = 1'b0;
      empty_idx = '0;
      for (int i = FRAME_COUNT - 1; i >= 0; i--) begin
         if (valid_ff[i] && (page_ff[i] == req_page_ff)) begin
            any_hit = 1'b1;
            hit_idx = HW'(i);
         end
         if (!valid_ff[i]) begin
            any_empty = 1'b1;
            empty_idx = HW'(i);
         end
      end
   end

   assign next_hand = (hand_ff == HW'(FRAME_COUNT - 1)) ? '0 : hand_ff + HW'(1);

   assign status.hit         = any_hit;
   assign status.has_empty   = any_empty;
   assign status.use_at_hand = use_ff[hand_ff];

   always_comb begin
      page_in     = page_ff;
      valid_in    = valid_ff;
      use_in      = use_ff;
      hand_in     = hand_ff;
      req_page_in = req_page_ff;
      hit_in      = hit_ff;
      frame_in    = frame_ff;
      ev_valid_in = ev_valid_ff;
      ev_page_in  = ev_page_ff;
      if (cmd.capture) begin
         req_page_in = req_access_address[ADDR_W-1:PAGE_SHIFT];
      end
      if (cmd.hit_update) begin
         use_in[hit_idx] = 1'b1;
         hit_in          = 1'b1;
         frame_in        = hit_idx;
         ev_valid_in     = 1'b0;
         ev_page_in      = '0;
      end
      if (cmd.fill_empty) begin
         page_in[empty_idx]  = req_page_ff;
         valid_in[empty_idx] = 1'b1;
         use_in[empty_idx]   = 1'b1;
         hit_in              = 1'b0;
         frame_in            = empty_idx;
         ev_valid_in         = 1'b0;
         ev_page_in          = '0;
      end
      if (cmd.clear_step) begin
         use_in[hand_ff] = 1'b0;
         hand_in         = next_hand;
      end
      if (cmd.replace) begin
         ev_page_in        = page_ff[hand_ff];
         ev_valid_in       = 1'b1;
         page_in[hand_ff]  = req_page_ff;
         use_in[hand_ff]   = 1'b1;
         hit_in            = 1'b0;
         frame_in          = hand_ff;
         hand_in           = next_hand;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         use_ff   <= '0;
         hand_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         use_ff   <= use_in;
         hand_ff  <= hand_in;
      end
   end

   always_ff @(posedge clock) begin
      page_ff     <= page_in;
      req_page_ff <= req_page_in;
      hit_ff      <= hit_in;
      frame_ff    <= frame_in;
      ev_valid_ff <= ev_valid_in;
      ev_page_ff  <= ev_page_in;
   end

   assign rsp_hit           = hit_ff;
   assign rsp_frame_index   = FRAME_OUT_W'(frame_ff);
   assign rsp_page_number   = req_page_ff;
   assign rsp_evicted_valid = ev_valid_ff;
   assign rsp_evicted_page  = ev_page_ff;

   a_replace_clear_use: assert property (@(posedge clock) disable iff (reset)
      cmd.replace |-> !use_ff[hand_ff])
      else $error("replace issued on a frame whose use bit is set");

   a_replace_full: assert property (@(posedge clock) disable iff (reset)
      cmd.replace |-> (valid_ff == {FRAME_COUNT{1'b1}}))
      else $error("replace issued while an empty frame exists");

endmodule

// File: hdl/cpr_controller.sv
// ----------------------------------------------------------------------------
// Clock page replacement controller
// Sequences lookup, fill, clock sweep and result strobe for each access.
// ----------------------------------------------------------------------------
module cpr_controller
   import cpr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  status_type status,
   output cmd_type    cmd,
   output logic       rsp_valid
);

   ctrl_state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_MATCH;
         end
         ST_MATCH: begin
            if (status.hit || status.has_empty) state_in = ST_REPLY;
            else state_in = ST_SWEEP;
         end
         ST_SWEEP: begin
            if (!status.use_at_hand) state_in = ST_REPLY;
         end
         ST_REPLY: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      busy      = 1'b1;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            busy        = 1'b0;
            cmd.capture = start;
         end
         ST_MATCH: begin
            cmd.hit_update = status.hit;
            cmd.fill_empty = !status.hit && status.has_empty;
         end
         ST_SWEEP: begin
            cmd.clear_step = status.use_at_hand;
            cmd.replace    = !status.use_at_hand;
         end
         ST_REPLY: begin
            rsp_valid = 1'b1;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

   a_accept_to_match: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (state_ff == ST_MATCH))
      else $error("accepted beat did not enter lookup");

   a_reply_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> (!rsp_valid && !busy))
      else $error("result strobe longer than one cycle");

   a_hit_replies: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MATCH && status.hit) |=> rsp_valid)
      else $error("hit did not reply in the next cycle");

endmodule

// File: hdl/clock_page_replacement_top.sv
// ----------------------------------------------------------------------------
// Clock page replacement top level
// Second-chance replacement over FRAME_COUNT frames, one result per access.
// ----------------------------------------------------------------------------
// An access is taken when start is high and busy is low; busy then stays high
// until the result has been strobed on rsp_valid for one cycle, and the
// result must be taken in that cycle. A hit or a fill of an empty frame
// is handled in ST_MATCH and strobes its result from ST_REPLY. A
// replacement moves on from ST_MATCH to ST_SWEEP, which walks the clock hand
// one frame per cycle, clearing each set use bit it passes, then replaces the
// frame at the hand and goes to ST_REPLY to strobe. The hand clears at most
// FRAME_COUNT use bits before it finds a clear one. The next access can be
// taken in the cycle after the strobe. No clearing pass after reset.
module clock_page_replacement_top
   import cpr_pkg::*;
#(
   parameter int FRAME_COUNT = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [ADDR_W-1:0]      req_access_address,
   output logic                   rsp_valid,
   output logic                   rsp_hit,
   output logic [FRAME_OUT_W-1:0] rsp_frame_index,
   output logic [PAGE_W-1:0]      rsp_page_number,
   output logic                   rsp_evicted_valid,
   output logic [PAGE_W-1:0]      rsp_evicted_page
);

   cmd_type    cmd;
   status_type status;

   cpr_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .status    (status),
      .cmd       (cmd),
      .rsp_valid (rsp_valid)
   );

   cpr_datapath #(
      .FRAME_COUNT (FRAME_COUNT)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_access_address (req_access_address),
      .rsp_hit            (rsp_hit),
      .rsp_frame_index    (rsp_frame_index),
      .rsp_page_number    (rsp_page_number),
      .rsp_evicted_valid  (rsp_evicted_valid),
      .rsp_evicted_page   (rsp_evicted_page)
   );

endmodule
